### hw/rtl/vtc_rss_pkg.sv
// shared types and constants for the voltage-to-code rss window block
// no dependencies; imported by every module of the block

package vtc_rss_pkg;

	// word layout on the stream ports
	localparam int VOLT_W     = 16;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_CODE_W = 8;
	localparam int OUT_RSS_W  = 9;
	localparam int OUT_DATA_W = 40;

	// voltage format: 12 fraction bits, 5 V full scale
	localparam int FRAC_BITS      = 12;
	localparam int FULL_SCALE_RAW = 5 << FRAC_BITS;
	localparam int MAG_W          = VOLT_W + 1;
	localparam int SAT_MAG_W      = 15;

	// divide by 5 as multiply by ceil(2^21 / 5), exact below 699050
	localparam int DIV5_MUL   = 419431;
	localparam int DIV5_MUL_W = 19;
	localparam int DIV5_SHIFT = 21;

	// length of the conversion wait after accept; the first of the four
	// conversion stages loads at the accept edge
	localparam int CONV_LAT = 3;

	// which taps feed the sum of squares
	typedef enum logic [1:0] {
		WIN_MID,	// before, pending, current
		WIN_END,	// before, current, current
		WIN_ONE		// current on all three taps
	} win_sel_t;

	// update applied to the per-lane window history
	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_SHIFT,	// before takes pending
		UPD_FIRST,	// before and pending take current
		UPD_PEND,	// pending takes current
		UPD_CLEAR	// history back to zero
	} upd_t;

	typedef struct packed {
		logic     load_cur;
		logic     start;
		win_sel_t sel;
		upd_t     upd;
	} lane_ctrl_t;

endpackage

### hw/rtl/vtc_rss_conv.sv
// voltage to clamped converter code, four register stages
// depends on vtc_rss_pkg

module vtc_rss_conv #(
	parameter int CODE_BITS = 8
) (
	input  logic                                   clk,
	input  logic signed [vtc_rss_pkg::VOLT_W-1:0]  volt,
	output logic        [CODE_BITS-1:0]            code
);
	import vtc_rss_pkg::*;

	localparam int PROD_W = SAT_MAG_W + CODE_BITS;
	localparam int T_W    = PROD_W - FRAC_BITS;
	localparam int LO_W   = T_W / 2;
	localparam int HI_W   = T_W - LO_W;
	localparam int FULL_W = T_W + DIV5_MUL_W;
	localparam int Q_W    = FULL_W - DIV5_SHIFT;

	logic [VOLT_W-1:0]          raw;
	logic [MAG_W-1:0]           mag_c;
	logic [SAT_MAG_W-1:0]       mag_s1;
	logic                       sat_s1, sat_s2, sat_s3;
	logic [PROD_W-1:0]          prod_c;
	logic [T_W-1:0]             t_s2;
	logic [HI_W+DIV5_MUL_W-1:0] hi_s3;
	logic [LO_W+DIV5_MUL_W-1:0] lo_s3;
	logic [FULL_W-1:0]          full_c;
	logic [Q_W-1:0]             q_c;

	// magnitude, with -32768 giving 32768
	assign raw   = volt;
	assign mag_c = raw[VOLT_W-1] ? MAG_W'(18'h10000 - {2'b00, raw}) : {1'b0, raw};

	// scale by code max, drop the fraction bits
	assign prod_c = mag_s1 * {CODE_BITS{1'b1}};

	// recombine partial products of the reciprocal multiply
	assign full_c = (FULL_W'(hi_s3) << LO_W) + FULL_W'(lo_s3);
	assign q_c    = full_c[FULL_W-1:DIV5_SHIFT];

	always_ff @(posedge clk) begin
		// s1: magnitude and saturation at full scale
		sat_s1 <= (mag_c >= MAG_W'(FULL_SCALE_RAW));
		mag_s1 <= mag_c[SAT_MAG_W-1:0];
		// s2: scaled value in whole volts times code max
		sat_s2 <= sat_s1;
		t_s2   <= prod_c[PROD_W-1:FRAC_BITS];
		// s3: divide by five, split into two partial products
		sat_s3 <= sat_s2;
		hi_s3  <= t_s2[T_W-1:LO_W] * DIV5_MUL_W'(DIV5_MUL);
		lo_s3  <= t_s2[LO_W-1:0] * DIV5_MUL_W'(DIV5_MUL);
		// s4: clamp
		code   <= sat_s3 ? {CODE_BITS{1'b1}} : q_c[CODE_BITS-1:0];
	end

endmodule

### hw/rtl/vtc_rss_isqrt.sv
// iterative floor square root, one root bit per cycle
// depends on vtc_rss_pkg

module vtc_rss_isqrt #(
	parameter int CODE_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*CODE_BITS+1:0]   radicand,
	output logic                     busy,
	output logic [CODE_BITS:0]       root
);
	import vtc_rss_pkg::*;

	localparam int RAD_W  = 2 * CODE_BITS + 2;
	localparam int ROOT_W = CODE_BITS + 1;
	localparam int REM_W  = ROOT_W + 1;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              ge;

	// bring down two radicand bits and try root*4+1
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = (REM_W+2)'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);

	assign busy = (cnt_q != '0);
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(ROOT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

endmodule

### hw/rtl/vtc_rss_lane.sv
// one channel lane: code conversion, three-tap window history, root unit
// depends on vtc_rss_pkg, vtc_rss_conv, vtc_rss_isqrt

module vtc_rss_lane #(
	parameter int CODE_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [vtc_rss_pkg::VOLT_W-1:0] volt,
	input  vtc_rss_pkg::lane_ctrl_t               ctrl,
	output logic                                  busy,
	output logic        [CODE_BITS-1:0]           center,
	output logic        [CODE_BITS:0]             rss
);
	import vtc_rss_pkg::*;

	localparam int RAD_W = 2 * CODE_BITS + 2;

	logic [CODE_BITS-1:0]   code;
	logic [CODE_BITS-1:0]   cur_q, pend_q, bef_q, ctr_q;
	logic [CODE_BITS-1:0]   tap_a, tap_b, tap_c;
	logic [2*CODE_BITS-1:0] sq_a, sq_b, sq_c;
	logic [RAD_W-1:0]       sum_c;

	vtc_rss_conv #(
		.CODE_BITS (CODE_BITS)
	) u_conv (
		.clk  (clk),
		.volt (volt),
		.code (code)
	);

	// tap selection for the window being started
	always_comb begin
		unique case (ctrl.sel)
			WIN_MID: begin
				tap_a = bef_q;
				tap_b = pend_q;
				tap_c = cur_q;
			end
			WIN_END: begin
				tap_a = bef_q;
				tap_b = cur_q;
				tap_c = cur_q;
			end
			WIN_ONE: begin
				tap_a = cur_q;
				tap_b = cur_q;
				tap_c = cur_q;
			end
			default: begin
				tap_a = cur_q;
				tap_b = cur_q;
				tap_c = cur_q;
			end
		endcase
	end

	// sum of squares feeding the root unit
	assign sq_a  = tap_a * tap_a;
	assign sq_b  = tap_b * tap_b;
	assign sq_c  = tap_c * tap_c;
	assign sum_c = RAD_W'(sq_a) + RAD_W'(sq_b) + RAD_W'(sq_c);

	vtc_rss_isqrt #(
		.CODE_BITS (CODE_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.start),
		.radicand (sum_c),
		.busy     (busy),
		.root     (rss)
	);

	// window history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bef_q  <= '0;
			pend_q <= '0;
		end else begin
			unique case (ctrl.upd)
				UPD_NONE: begin
				end
				UPD_SHIFT: begin
					bef_q <= pend_q;
				end
				UPD_FIRST: begin
					bef_q  <= cur_q;
					pend_q <= cur_q;
				end
				UPD_PEND: begin
					pend_q <= cur_q;
				end
				UPD_CLEAR: begin
					bef_q  <= '0;
					pend_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// current sample and the center tap of the running window
	always_ff @(posedge clk) begin
		if (ctrl.load_cur) begin
			cur_q <= code;
		end
		if (ctrl.start) begin
			ctr_q <= (ctrl.sel == WIN_MID) ? pend_q : cur_q;
		end
	end

	assign center = ctr_q;

endmodule

### hw/rtl/voltage_to_code_rss_window_top.sv
// top level of the voltage-to-code rss window block: sequencer, two lanes, output merge
// depends on vtc_rss_pkg and vtc_rss_lane

// Each input word carries an X and a Y voltage; both are turned into clamped codes and
// each sample leaves as a word with its codes and the floor root of the summed squares
// of its three-sample window, one word behind, so a word marked tlast releases two
// when a sample is held and one otherwise. The X and Y lanes run side by side. One
// word is worked on at a time: accept, code conversion, load and plan of the window,
// then the per-lane iterative root unit, which yields one root bit a cycle. A tlast
// word with a held sample runs the root unit twice. The output register lets the next
// word be accepted while a result still waits on m_axis_tready.

module voltage_to_code_rss_window_top #(
	parameter int CODE_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [15:0] volt_x, [31:16] volt_y
	input  logic [vtc_rss_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// end_of_run
	input  logic                                     s_axis_tlast,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// [7:0] code_x, [15:8] code_y, [24:16] rss_x, [33:25] rss_y, rest zero
	output logic [vtc_rss_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// final_result
	output logic                                     m_axis_tlast
);
	import vtc_rss_pkg::*;

	localparam int CNT_W = $clog2(CONV_LAT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_LOAD,
		ST_PLAN,
		ST_SQRT
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        pend_v_q, last_q, fin_q;
	logic                        out_valid_q, out_last_q;
	logic [OUT_CODE_W-1:0]       code_x_q, code_y_q;
	logic [OUT_RSS_W-1:0]        rss_x_q, rss_y_q;
	lane_ctrl_t                  ctrl;
	logic                        busy_x, busy_y;
	logic [CODE_BITS-1:0]        ctr_x, ctr_y;
	logic [CODE_BITS:0]          root_x, root_y;
	logic                        out_free, root_done, emit;
	logic [OUT_CODE_W+CODE_BITS-1:0] cx_ext, cy_ext;
	logic [OUT_RSS_W+CODE_BITS:0]    rx_ext, ry_ext;

	// lanes
	vtc_rss_lane #(
		.CODE_BITS (CODE_BITS)
	) u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.volt   (s_axis_tdata[VOLT_W-1:0]),
		.ctrl   (ctrl),
		.busy   (busy_x),
		.center (ctr_x),
		.rss    (root_x)
	);

	vtc_rss_lane #(
		.CODE_BITS (CODE_BITS)
	) u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.volt   (s_axis_tdata[2*VOLT_W-1:VOLT_W]),
		.ctrl   (ctrl),
		.busy   (busy_y),
		.center (ctr_y),
		.rss    (root_y)
	);

	assign out_free  = !out_valid_q || m_axis_tready;
	assign root_done = !busy_x;
	assign emit      = (state_q == ST_SQRT) && root_done && out_free;

	// fit lane results to the output field widths
	assign cx_ext = {{OUT_CODE_W{1'b0}}, ctr_x};
	assign cy_ext = {{OUT_CODE_W{1'b0}}, ctr_y};
	assign rx_ext = {{OUT_RSS_W{1'b0}}, root_x};
	assign ry_ext = {{OUT_RSS_W{1'b0}}, root_y};

	// lane control decoded from the sequencer state
	always_comb begin
		ctrl.load_cur = 1'b0;
		ctrl.start    = 1'b0;
		ctrl.sel      = WIN_MID;
		ctrl.upd      = UPD_NONE;
		unique case (state_q)
			ST_LOAD: begin
				ctrl.load_cur = 1'b1;
			end
			ST_PLAN: begin
				priority if (pend_v_q) begin
					ctrl.start = 1'b1;
					ctrl.sel   = WIN_MID;
					ctrl.upd   = UPD_SHIFT;
				end else if (last_q) begin
					ctrl.start = 1'b1;
					ctrl.sel   = WIN_ONE;
				end else begin
					ctrl.upd = UPD_FIRST;
				end
			end
			ST_SQRT: begin
				if (emit) begin
					priority if (fin_q) begin
						ctrl.upd = UPD_CLEAR;
					end else if (last_q) begin
						ctrl.start = 1'b1;
						ctrl.sel   = WIN_END;
					end else begin
						ctrl.upd = UPD_PEND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			last_q      <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			code_x_q    <= '0;
			code_y_q    <= '0;
			rss_x_q     <= '0;
			rss_y_q     <= '0;
		end else begin
			if (out_valid_q && m_axis_tready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						last_q  <= s_axis_tlast;
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CONV_LAT - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					priority if (pend_v_q) begin
						fin_q   <= 1'b0;
						state_q <= ST_SQRT;
					end else if (last_q) begin
						fin_q   <= 1'b1;
						state_q <= ST_SQRT;
					end else begin
						pend_v_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_SQRT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						out_last_q  <= fin_q;
						code_x_q    <= cx_ext[OUT_CODE_W-1:0];
						code_y_q    <= cy_ext[OUT_CODE_W-1:0];
						rss_x_q     <= rx_ext[OUT_RSS_W-1:0];
						rss_y_q     <= ry_ext[OUT_RSS_W-1:0];
						priority if (fin_q) begin
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else if (last_q) begin
							fin_q <= 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {(OUT_DATA_W - 2*OUT_CODE_W - 2*OUT_RSS_W)'(0),
		rss_y_q, rss_x_q, code_y_q, code_x_q};

	// both lanes step their root units in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		busy_x == busy_y)
		else $error("root units of the two lanes out of step");

	// no word is taken while a root is still being worked out
	a_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !busy_x)
		else $error("input accepted while the root unit is busy");

	// the final result of a run leaves the window empty
	a_final_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && fin_q) |=> (!pend_v_q && state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast))
		else $error("window not emptied after the final result");

	// a first sample that is not the last is held for its neighbor
	a_first_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLAN && !pend_v_q && !last_q) |=> pend_v_q)
		else $error("first sample of a run not held");

endmodule
